### design/radius_visibility_tracker_macros.svh
// Assertion macros for the radius visibility tracker checker.
// Expects signals named clk and rst_n in the scope of each use.
`ifndef RADIUS_VISIBILITY_TRACKER_MACROS_SVH
`define RADIUS_VISIBILITY_TRACKER_MACROS_SVH

// Same-cycle implication, off while in reset.
`define RVT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("radius_visibility_tracker: check failed");

// Next-cycle implication, off while in reset.
`define RVT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("radius_visibility_tracker: check failed");

// Next-cycle implication that also holds across reset.
`define RVT_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("radius_visibility_tracker: check failed");

`endif

### design/rvt_pkg.sv
// Shared types and constants of the radius visibility tracker.
// No dependencies.
`default_nettype none

package rvt_pkg;

  localparam int MAX_SPHERES = 32;
  localparam int IDX_W       = $clog2(MAX_SPHERES);
  localparam int CNT_W       = $clog2(MAX_SPHERES + 1);
  localparam int OUT_IDX_W   = 5;

  localparam int COORD_W  = 24;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int SQ_W     = 2 * DIFF_W;
  localparam int SUM_W    = SQ_W + 2;
  localparam int RADIUS_W = 16;
  localparam int R2_W     = 2 * RADIUS_W;

  localparam logic [RADIUS_W-1:0] RADIUS_RST = 16'd461;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_POS  = 1'b1;

  localparam int CQ_DEPTH = 2;
  localparam int CQ_PTR_W = 1;
  localparam int CQ_CNT_W = 2;
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = 2;
  localparam int OQ_CNT_W = 3;

  typedef enum logic [1:0] {
    EV_ENTER = 2'd0,
    EV_LEFT  = 2'd1,
    EV_DONE  = 2'd2
  } event_t;

  // Command from the front end to the walk engine.
  typedef struct packed {
    logic               wr_en;
    logic               pass_en;
    logic               walk;
    logic               set_pos;
    logic [IDX_W-1:0]   idx;
    logic [CNT_W-1:0]   cnt;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
  } cmd_t;

  typedef struct packed {
    event_t               ev;
    logic [OUT_IDX_W-1:0] idx;
    logic [COORD_W-1:0]   x;
    logic [COORD_W-1:0]   y;
    logic [COORD_W-1:0]   z;
    logic                 last;
  } result_t;

endpackage

`default_nettype wire

### design/rvt_front.sv
// Front end: accepts input transactions and turns them into walk commands.
// Depends on rvt_pkg.
`default_nettype none

module rvt_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        push,
  input  wire logic                        full,
  input  wire logic                        in_op,
  input  wire logic [rvt_pkg::COORD_W-1:0] in_x_coord,
  input  wire logic [rvt_pkg::COORD_W-1:0] in_y_coord,
  input  wire logic [rvt_pkg::COORD_W-1:0] in_z_coord,
  input  wire logic                        in_last_center,
  output logic                             cq_push,
  output rvt_pkg::cmd_t                    cq_data
);
  import rvt_pkg::*;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             loaded_r, loaded_nxt;
  logic             has_pos_r, has_pos_nxt;
  logic             accept;

  assign accept = push && !full;

  always_comb begin
    count_nxt   = count_r;
    loaded_nxt  = loaded_r;
    has_pos_nxt = has_pos_r;
    cq_data     = '0;
    cq_data.x   = in_x_coord;
    cq_data.y   = in_y_coord;
    cq_data.z   = in_z_coord;
    cq_push     = 1'b0;
    if (accept) begin
      if (in_op == OP_POS) begin
        has_pos_nxt     = 1'b1;
        cq_data.set_pos = 1'b1;
        cq_data.pass_en = 1'b1;
        cq_data.walk    = loaded_r;
        cq_data.cnt     = count_r;
        cq_push         = 1'b1;
      end else if (!loaded_r) begin
        // drop centers once the table is full
        if (count_r < CNT_W'(MAX_SPHERES)) begin
          cq_data.wr_en = 1'b1;
          cq_data.idx   = count_r[IDX_W-1:0];
          count_nxt     = count_r + 1'b1;
        end
        if (in_last_center) begin
          loaded_nxt      = 1'b1;
          cq_data.pass_en = has_pos_r;
          cq_data.walk    = 1'b1;
          cq_data.cnt     = count_nxt;
        end
        cq_push = cq_data.wr_en || cq_data.pass_en;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      loaded_r  <= 1'b0;
      has_pos_r <= 1'b0;
    end else begin
      count_r   <= count_nxt;
      loaded_r  <= loaded_nxt;
      has_pos_r <= has_pos_nxt;
    end
  end

endmodule

`default_nettype wire

### design/rvt_cmdq.sv
// Two-entry command queue between the front end and the walk engine.
// Depends on rvt_pkg.
`default_nettype none

module rvt_cmdq (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr_en,
  input  wire rvt_pkg::cmd_t wr_data,
  input  wire logic          rd_en,
  output rvt_pkg::cmd_t      rd_data,
  output logic               full,
  output logic               empty
);
  import rvt_pkg::*;

  cmd_t                entries_r [CQ_DEPTH];
  logic [CQ_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CQ_CNT_W-1:0] cnt_r;
  logic                do_wr, do_rd;

  assign full    = (cnt_r == CQ_CNT_W'(CQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = entries_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

`default_nettype wire

### design/rvt_back.sv
// Walk engine: center memory, visibility flags and the distance pipeline.
// Depends on rvt_pkg.
`default_nettype none

module rvt_back (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_wr_en,
  input  wire logic [rvt_pkg::RADIUS_W-1:0] cfg_wr_data,
  input  wire logic                         cq_empty,
  input  wire rvt_pkg::cmd_t                cq_head,
  output logic                              cq_pop,
  input  wire logic [rvt_pkg::OQ_CNT_W-1:0] oq_count,
  output logic                              oq_push,
  output rvt_pkg::result_t                  oq_data
);
  import rvt_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_FINISH} state_t;

  state_t                 state_r, state_nxt;
  logic [CNT_W-1:0]       walk_idx_r, walk_idx_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [3*COORD_W-1:0]   pos_r, pos_nxt;
  logic [RADIUS_W-1:0]    radius_r, radius_nxt;
  logic [R2_W-1:0]        r2_r, r2_nxt;
  logic [MAX_SPHERES-1:0] vis_r, vis_nxt;

  logic                   st1_v_r, st1_v_nxt;
  logic [IDX_W-1:0]       st1_idx_r, st1_idx_nxt;
  logic                   st2_v_r, st2_v_nxt;
  logic [IDX_W-1:0]       st2_idx_r, st2_idx_nxt;
  logic [3*COORD_W-1:0]   st2_ctr_r, st2_ctr_nxt;
  logic [SQ_W-1:0]        sq_x_r, sq_y_r, sq_z_r;
  logic [SQ_W-1:0]        sq_x_nxt, sq_y_nxt, sq_z_nxt;

  logic [3*COORD_W-1:0]   mem [MAX_SPHERES];
  logic [3*COORD_W-1:0]   rd_data_r;
  logic                   issue;
  logic [IDX_W-1:0]       rd_addr;
  logic                   mem_we;

  logic [DIFF_W-1:0]      dx, dy, dz, ax, ay, az;
  logic [SUM_W-1:0]       d2;
  logic                   inside_r2;
  logic [OQ_CNT_W-1:0]    in_flight;

  function automatic logic [DIFF_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                 input logic [COORD_W-1:0] b);
    logic [DIFF_W-1:0] d;
    d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    return d[DIFF_W-1] ? (~d + 1'b1) : d;
  endfunction

  // Stage 1: squared axis distances of the entry just read.
  always_comb begin
    ax = abs_diff(pos_r[3*COORD_W-1:2*COORD_W], rd_data_r[3*COORD_W-1:2*COORD_W]);
    ay = abs_diff(pos_r[2*COORD_W-1:COORD_W], rd_data_r[2*COORD_W-1:COORD_W]);
    az = abs_diff(pos_r[COORD_W-1:0], rd_data_r[COORD_W-1:0]);
    dx = ax;
    dy = ay;
    dz = az;
    sq_x_nxt = dx * dx;
    sq_y_nxt = dy * dy;
    sq_z_nxt = dz * dz;
  end

  // Stage 2: sum and compare against radius squared.
  assign d2        = SUM_W'(sq_x_r) + SUM_W'(sq_y_r) + SUM_W'(sq_z_r);
  assign inside_r2 = (d2 <= SUM_W'(r2_r));
  assign in_flight = oq_count + OQ_CNT_W'(st1_v_r) + OQ_CNT_W'(st2_v_r);

  always_comb begin
    state_nxt    = state_r;
    walk_idx_nxt = walk_idx_r;
    cnt_nxt      = cnt_r;
    pos_nxt      = pos_r;
    radius_nxt   = cfg_wr_en ? cfg_wr_data : radius_r;
    r2_nxt       = radius_r * radius_r;
    vis_nxt      = vis_r;
    cq_pop       = 1'b0;
    mem_we       = 1'b0;
    issue        = 1'b0;
    rd_addr      = walk_idx_r[IDX_W-1:0];
    oq_push      = 1'b0;
    oq_data      = '0;

    st1_v_nxt   = 1'b0;
    st1_idx_nxt = st1_idx_r;
    st2_v_nxt   = st1_v_r;
    st2_idx_nxt = st1_idx_r;
    st2_ctr_nxt = rd_data_r;

    if (st2_v_r) begin
      oq_data.idx = OUT_IDX_W'(st2_idx_r);
      oq_data.x   = st2_ctr_r[3*COORD_W-1:2*COORD_W];
      oq_data.y   = st2_ctr_r[2*COORD_W-1:COORD_W];
      oq_data.z   = st2_ctr_r[COORD_W-1:0];
      if (vis_r[st2_idx_r] && !inside_r2) begin
        oq_data.ev          = EV_LEFT;
        oq_push             = 1'b1;
        vis_nxt[st2_idx_r]  = 1'b0;
      end else if (!vis_r[st2_idx_r] && inside_r2) begin
        oq_data.ev          = EV_ENTER;
        oq_push             = 1'b1;
        vis_nxt[st2_idx_r]  = 1'b1;
      end
    end

    case (state_r)
      S_IDLE: begin
        if (!cq_empty) begin
          cq_pop = 1'b1;
          mem_we = cq_head.wr_en;
          if (cq_head.set_pos) begin
            pos_nxt = {cq_head.x, cq_head.y, cq_head.z};
          end
          if (cq_head.pass_en) begin
            cnt_nxt      = cq_head.cnt;
            walk_idx_nxt = '0;
            if (cq_head.walk && (cq_head.cnt != '0)) begin
              state_nxt = S_WALK;
            end else begin
              state_nxt = S_FINISH;
            end
          end
        end
      end
      S_WALK: begin
        // advance only with room reserved in the result queue
        if (in_flight < OQ_CNT_W'(OQ_DEPTH - 1)) begin
          issue       = 1'b1;
          st1_v_nxt   = 1'b1;
          st1_idx_nxt = walk_idx_r[IDX_W-1:0];
          if (walk_idx_r + 1'b1 == cnt_r) begin
            state_nxt = S_FINISH;
          end else begin
            walk_idx_nxt = walk_idx_r + 1'b1;
          end
        end
      end
      S_FINISH: begin
        if (!st1_v_r && !st2_v_r && (oq_count < OQ_CNT_W'(OQ_DEPTH))) begin
          oq_push      = 1'b1;
          oq_data      = '0;
          oq_data.ev   = EV_DONE;
          oq_data.last = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cq_head.idx] <= {cq_head.x, cq_head.y, cq_head.z};
    end
    if (issue) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      walk_idx_r <= '0;
      cnt_r      <= '0;
      pos_r      <= '0;
      radius_r   <= RADIUS_RST;
      r2_r       <= '0;
      vis_r      <= '0;
      st1_v_r    <= 1'b0;
      st2_v_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      walk_idx_r <= walk_idx_nxt;
      cnt_r      <= cnt_nxt;
      pos_r      <= pos_nxt;
      radius_r   <= radius_nxt;
      r2_r       <= r2_nxt;
      vis_r      <= vis_nxt;
      st1_v_r    <= st1_v_nxt;
      st2_v_r    <= st2_v_nxt;
    end
    st1_idx_r <= st1_idx_nxt;
    st2_idx_r <= st2_idx_nxt;
    st2_ctr_r <= st2_ctr_nxt;
    sq_x_r    <= sq_x_nxt;
    sq_y_r    <= sq_y_nxt;
    sq_z_r    <= sq_z_nxt;
  end

endmodule

`default_nettype wire

### design/rvt_outq.sv
// Four-entry result queue that drives the result ports.
// Depends on rvt_pkg.
`default_nettype none

module rvt_outq (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         wr_en,
  input  wire rvt_pkg::result_t             wr_data,
  input  wire logic                         rd_en,
  output rvt_pkg::result_t                  rd_data,
  output logic                              empty,
  output logic [rvt_pkg::OQ_CNT_W-1:0]      count
);
  import rvt_pkg::*;

  result_t             entries_r [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [OQ_CNT_W-1:0] cnt_r;
  logic                do_wr, do_rd;

  assign empty   = (cnt_r == '0);
  assign count   = cnt_r;
  assign do_wr   = wr_en && (cnt_r != OQ_CNT_W'(OQ_DEPTH));
  assign do_rd   = rd_en && !empty;
  assign rd_data = entries_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

`default_nettype wire

### design/radius_visibility_tracker.sv
// Top level of the radius visibility tracker: front end, command queue,
// walk engine and result queue. Depends on rvt_pkg and the rvt_* modules.
//
//   channel   ports                         handshake
//   input     in_op, in_*_coord, in_last_*  push / full
//   result    out_event_res ... out_last    empty / pop
//   config    cfg_wr_data (radius)          cfg_wr_en, no wait
//
// A load transaction is queued and written to the center memory in the cycle
// after it is accepted if the walk engine is idle, or once the pass in progress
// has ended. A pass over N stored centers runs through the command pop, one
// memory read per center, two pipeline stages to drain, then the done marker.
// Reset is synchronous on rst_n; the center memory is not cleared. The walk
// pauses whenever the four-entry result queue has no room for what is in
// flight; full rises when the two-entry command queue is full.
`default_nettype none

module radius_visibility_tracker (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         push,
  output logic                              full,
  input  wire logic                         in_op,
  input  wire logic [rvt_pkg::COORD_W-1:0]  in_x_coord,
  input  wire logic [rvt_pkg::COORD_W-1:0]  in_y_coord,
  input  wire logic [rvt_pkg::COORD_W-1:0]  in_z_coord,
  input  wire logic                         in_last_center,
  output logic                              empty,
  input  wire logic                         pop,
  output logic [1:0]                        out_event_res,
  output logic [rvt_pkg::OUT_IDX_W-1:0]     out_sphere_index,
  output logic [rvt_pkg::COORD_W-1:0]       out_center_x,
  output logic [rvt_pkg::COORD_W-1:0]       out_center_y,
  output logic [rvt_pkg::COORD_W-1:0]       out_center_z,
  output logic                              out_last,
  input  wire logic                         cfg_wr_en,
  input  wire logic [rvt_pkg::RADIUS_W-1:0] cfg_wr_data
);
  import rvt_pkg::*;

  logic                cq_push, cq_pop, cq_empty;
  cmd_t                cq_wr_data, cq_head;
  logic                oq_push;
  result_t             oq_wr_data, oq_head;
  logic [OQ_CNT_W-1:0] oq_count;

  rvt_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_op          (in_op),
    .in_x_coord     (in_x_coord),
    .in_y_coord     (in_y_coord),
    .in_z_coord     (in_z_coord),
    .in_last_center (in_last_center),
    .cq_push        (cq_push),
    .cq_data        (cq_wr_data)
  );

  rvt_cmdq u_cmdq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cq_push),
    .wr_data (cq_wr_data),
    .rd_en   (cq_pop),
    .rd_data (cq_head),
    .full    (full),
    .empty   (cq_empty)
  );

  rvt_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cq_empty    (cq_empty),
    .cq_head     (cq_head),
    .cq_pop      (cq_pop),
    .oq_count    (oq_count),
    .oq_push     (oq_push),
    .oq_data     (oq_wr_data)
  );

  rvt_outq u_outq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (oq_push),
    .wr_data (oq_wr_data),
    .rd_en   (pop),
    .rd_data (oq_head),
    .empty   (empty),
    .count   (oq_count)
  );

  assign out_event_res    = oq_head.ev;
  assign out_sphere_index = oq_head.idx;
  assign out_center_x     = oq_head.x;
  assign out_center_y     = oq_head.y;
  assign out_center_z     = oq_head.z;
  assign out_last         = oq_head.last;

endmodule

`default_nettype wire

### design/rvt_checker.sv
// Port-level checks for the radius visibility tracker, bound to the top.
// Depends on rvt_pkg and radius_visibility_tracker_macros.svh.
`default_nettype none

`include "radius_visibility_tracker_macros.svh"

module rvt_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          full,
  input wire logic                          empty,
  input wire logic                          pop,
  input wire logic [1:0]                    out_event_res,
  input wire logic [rvt_pkg::OUT_IDX_W-1:0] out_sphere_index,
  input wire logic [rvt_pkg::COORD_W-1:0]   out_center_x,
  input wire logic [rvt_pkg::COORD_W-1:0]   out_center_y,
  input wire logic [rvt_pkg::COORD_W-1:0]   out_center_z,
  input wire logic                          out_last
);
  import rvt_pkg::*;

  logic                        show_done;
  logic                        show_event;
  logic                        done_zero;
  logic                        event_kind_ok;
  logic [$bits(result_t)-1:0]  out_word;

  assign show_done     = !empty && (out_event_res == EV_DONE);
  assign show_event    = !empty && (out_event_res != EV_DONE);
  assign done_zero     = (out_sphere_index == '0) && (out_center_x == '0) &&
                         (out_center_y == '0) && (out_center_z == '0);
  assign event_kind_ok = (out_event_res == EV_ENTER) || (out_event_res == EV_LEFT);
  assign out_word      = {out_event_res, out_sphere_index, out_center_x, out_center_y,
                          out_center_z, out_last};

  // Done marker carries zero index and center and closes the pass.
  `RVT_ASSERT_IMP(a_done_fields, show_done, out_last && done_zero)
  // Entered and left events never close a pass.
  `RVT_ASSERT_IMP(a_event_kind, show_event, !out_last && event_kind_ok)
  // Reset empties both queues.
  `RVT_ASSERT_RST(a_reset_clear, !rst_n, empty && !full)
  // A waiting result holds until popped.
  `RVT_ASSERT_NXT(a_result_hold, !empty && !pop, !empty && $stable(out_word))

endmodule

bind radius_visibility_tracker rvt_checker u_rvt_checker (.*);

`default_nettype wire
